/* hdl/xtea_pkg.sv */
package xtea_pkg;

  localparam int unsigned WORD_W          = 32;
  localparam int unsigned BLOCK_W         = 2 * WORD_W;
  localparam logic [WORD_W-1:0] XTEA_DELTA = 32'h9e37_79b9;
  localparam int unsigned HALF_ROUNDS_DEF = 64;
  localparam int unsigned KEY_WORDS       = 4;
  localparam int unsigned KSEL_W          = 2;
  localparam int unsigned HI_KSEL_LSB     = 11;
  localparam int unsigned CFG_IDX_W       = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KEY0 = 2'd0,
    CFG_KEY1 = 2'd1,
    CFG_KEY2 = 2'd2,
    CFG_KEY3 = 2'd3
  } cfg_reg_t;

  typedef logic [KEY_WORDS-1:0][WORD_W-1:0] xtea_key_t;

  typedef struct packed {
    logic              decipher;
    logic [WORD_W-1:0] v1;
    logic [WORD_W-1:0] v0;
  } xtea_blk_t;

  // xtea feistel mixing of one word
  function automatic logic [WORD_W-1:0] xtea_mix(input logic [WORD_W-1:0] v);
    return ((v << 4) ^ (v >> 5)) + v;
  endfunction

endpackage

/* hdl/xtea_hround.sv */
module xtea_hround #(
  parameter int unsigned HALF_ROUNDS = xtea_pkg::HALF_ROUNDS_DEF,
  parameter int unsigned STAGE       = 0
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                up_valid,
  output logic                up_ready,
  input  xtea_pkg::xtea_blk_t up_blk,
  input  xtea_pkg::xtea_key_t key,
  output logic                dn_valid,
  input  logic                dn_ready,
  output xtea_pkg::xtea_blk_t dn_blk
);
  import xtea_pkg::*;

  // running sum seen by this half-round, fixed per stage and direction
  localparam int unsigned ROUND_IDX = (STAGE + 1) / 2;
  localparam logic [63:0] ENC_PROD  = 64'(XTEA_DELTA) * 64'(ROUND_IDX);
  localparam logic [63:0] DEC_PROD  = 64'(XTEA_DELTA) * 64'((HALF_ROUNDS / 2) - ROUND_IDX);
  localparam logic [WORD_W-1:0] ENC_SUM = ENC_PROD[WORD_W-1:0];
  localparam logic [WORD_W-1:0] DEC_SUM = DEC_PROD[WORD_W-1:0];
  localparam bit EVEN = (STAGE % 2) == 0;
  localparam logic [KSEL_W-1:0] ENC_KSEL =
    EVEN ? ENC_SUM[KSEL_W-1:0] : ENC_SUM[HI_KSEL_LSB +: KSEL_W];
  localparam logic [KSEL_W-1:0] DEC_KSEL =
    EVEN ? DEC_SUM[HI_KSEL_LSB +: KSEL_W] : DEC_SUM[KSEL_W-1:0];

  logic              valid_r;
  xtea_blk_t         blk_r;
  xtea_blk_t         blk_nxt;
  logic              upd_v0;
  logic [WORD_W-1:0] enc_add;
  logic [WORD_W-1:0] dec_add;
  logic [WORD_W-1:0] mix_val;
  logic [WORD_W-1:0] tgt;
  logic [WORD_W-1:0] fval;
  logic [WORD_W-1:0] res;

  // enciphering touches v0 on even half-rounds, deciphering on odd ones
  assign upd_v0  = EVEN ^ up_blk.decipher;
  assign enc_add = ENC_SUM + key[ENC_KSEL];
  assign dec_add = DEC_SUM + key[DEC_KSEL];
  assign mix_val = xtea_mix(upd_v0 ? up_blk.v1 : up_blk.v0);
  assign tgt     = upd_v0 ? up_blk.v0 : up_blk.v1;
  assign fval    = mix_val ^ (up_blk.decipher ? dec_add : enc_add);
  assign res     = up_blk.decipher ? (tgt - fval) : (tgt + fval);

  always_comb begin
    blk_nxt = up_blk;
    if (upd_v0) begin
      blk_nxt.v0 = res;
    end else begin
      blk_nxt.v1 = res;
    end
  end

  // a stage takes new data when empty or when its contents move on
  assign up_ready = !valid_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      blk_r <= blk_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_blk   = blk_r;

endmodule

/* hdl/xtea_block_cipher_unit.sv */
// xtea block cipher, 64-bit block, 128-bit key, one half-round per stage.
// input transfer: in_tdata carries the block, in_tuser selects encipher (0)
// or decipher (1). output transfer: out_tdata carries the processed block.
// key words are written on the cfg channel (index 0..3), which is always
// ready; write them only while no block is in flight.
// from input transfer to out_tvalid there is one register stage per
// half-round, the last one being the output register. throughput is one
// block per cycle while out_tready stays high.
// when the receiver stalls, a full stage holds its block while empty stages
// further up keep filling, so in_tready only drops once every stage between
// the input and the waiting output holds a block.
// reset empties the pipeline and clears all four key words to zero.
module xtea_block_cipher_unit #(
  parameter int unsigned HALF_ROUNDS = xtea_pkg::HALF_ROUNDS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [xtea_pkg::BLOCK_W-1:0]     in_tdata,  // block_low, block_high
  input  logic                             in_tuser,  // func
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [xtea_pkg::BLOCK_W-1:0]     out_tdata, // out_low, out_high
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [xtea_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [xtea_pkg::WORD_W-1:0]      cfg_data
);
  import xtea_pkg::*;

  xtea_key_t          key_r;
  logic [HALF_ROUNDS:0] stg_valid;
  logic [HALF_ROUNDS:0] stg_ready;
  xtea_blk_t          stg_blk [HALF_ROUNDS+1];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_KEY0: key_r[0] <= cfg_data;
        CFG_KEY1: key_r[1] <= cfg_data;
        CFG_KEY2: key_r[2] <= cfg_data;
        CFG_KEY3: key_r[3] <= cfg_data;
        default:  key_r    <= key_r;
      endcase
    end
  end

  assign stg_valid[0]       = in_tvalid;
  assign in_tready          = stg_ready[0];
  assign stg_blk[0]         = '{decipher: in_tuser,
                                v1:       in_tdata[BLOCK_W-1:WORD_W],
                                v0:       in_tdata[WORD_W-1:0]};
  assign stg_ready[HALF_ROUNDS] = out_tready;

  for (genvar h = 0; h < HALF_ROUNDS; h++) begin : g_hround
    xtea_hround #(
      .HALF_ROUNDS (HALF_ROUNDS),
      .STAGE       (h)
    ) u_hround (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (stg_valid[h]),
      .up_ready (stg_ready[h]),
      .up_blk   (stg_blk[h]),
      .key      (key_r),
      .dn_valid (stg_valid[h+1]),
      .dn_ready (stg_ready[h+1]),
      .dn_blk   (stg_blk[h+1])
    );
  end

  assign out_tvalid = stg_valid[HALF_ROUNDS];
  assign out_tdata  = {stg_blk[HALF_ROUNDS].v1, stg_blk[HALF_ROUNDS].v0};

  // a ready sink never backs up into the input
  a_sink_ready_flows: assert property (@(posedge clk) disable iff (!rst_n)
    out_tready |-> in_tready)
    else $error("input stalled although output is ready");

  // with no result waiting the pipeline cannot be full
  a_empty_out_accepts: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with an empty output stage");

  // an accepted block lands in the first stage
  a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> stg_valid[1])
    else $error("accepted block lost at the first stage");

endmodule
